>>> rtl/prtt_pkg.sv
// Types, codes and constants shared by the pending request timeout table.
`default_nettype none
package prtt_pkg;

	localparam int ENTRIES_DEF = 16;
	localparam int MAX_RESULTS = 16;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [1:0] ACT_ADD      = 2'd0;
	localparam logic [1:0] ACT_RESPONSE = 2'd1;
	localparam logic [1:0] ACT_CANCEL   = 2'd2;
	localparam logic [1:0] ACT_TICK     = 2'd3;

	localparam logic [1:0] EV_SUCCESS = 2'd0;
	localparam logic [1:0] EV_TIMEOUT = 2'd1;
	localparam logic [1:0] EV_REJECT  = 2'd2;

	typedef enum logic [1:0] {
		OP_ADD,
		OP_RESPONSE,
		OP_CANCEL,
		OP_TICK
	} op_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [31:0] request_id;
		logic [15:0] timeout_ticks;
		logic [7:0]  expected_responses;
		logic        silent;
	} request_t;

	typedef struct packed {
		logic [1:0]  event_res;
		logic [31:0] notice_id;
		logic [7:0]  remaining;
		logic        last;
	} notice_t;

	typedef struct packed {
		op_t         op;
		logic [31:0] request_id;
		logic [15:0] timeout_ticks;
		logic [7:0]  expected_responses;
		logic        silent;
	} cmd_t;

	typedef struct packed {
		logic [31:0] id;
		logic [15:0] timer;
		logic [7:0]  count;
	} slot_t;

endpackage
`default_nettype wire

>>> rtl/prtt_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module prtt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

>>> rtl/prtt_front.sv
// Front end: accepts request transfers, classifies the action and queues commands.
`default_nettype none
module prtt_front import prtt_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     request_valid,
	output logic          request_stall,
	input  wire request_t request,
	output logic          cmd_valid,
	input  wire logic     cmd_pop,
	output cmd_t          cmd
);

	localparam int QPW = $clog2(QUEUE_DEPTH);

	cmd_t             queue_q [QUEUE_DEPTH];
	logic [QPW-1:0]   wptr_q;
	logic [QPW-1:0]   rptr_q;
	logic [QPW:0]     count_q;
	logic             push;
	logic             pop;
	cmd_t             classified;

	always_comb begin
		classified.request_id         = request.request_id;
		classified.timeout_ticks      = request.timeout_ticks;
		classified.expected_responses = request.expected_responses;
		classified.silent             = request.silent;
		case (request.action)
			ACT_ADD:      classified.op = OP_ADD;
			ACT_RESPONSE: classified.op = OP_RESPONSE;
			ACT_CANCEL:   classified.op = OP_CANCEL;
			ACT_TICK:     classified.op = OP_TICK;
			default:      classified.op = OP_TICK;
		endcase
	end

	assign request_stall = (count_q == (QPW+1)'(QUEUE_DEPTH));
	assign push          = request_valid && !request_stall;
	assign cmd_valid     = (count_q != '0);
	assign pop           = cmd_pop && cmd_valid;
	assign cmd           = queue_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				queue_q[wptr_q] <= classified;
				wptr_q          <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

>>> rtl/prtt_back.sv
// Back end: scans the table for each command, updates entries and issues notices.
`default_nettype none
module prtt_back import prtt_pkg::*; #(
	parameter int ENTRIES = ENTRIES_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cmd_valid,
	output logic      cmd_pop,
	input  wire cmd_t cmd,
	output logic      notice_valid,
	input  wire logic notice_stall,
	output notice_t   notice
);

	localparam int IDXW = $clog2(ENTRIES);
	localparam int CNTW = IDXW + 1;
	localparam int NW   = $clog2(MAX_RESULTS + 1);
	localparam int SW   = $bits(slot_t);

	typedef enum logic [1:0] {
		B_IDLE,
		B_SCAN,
		B_DONE,
		B_FLUSH
	} state_t;

	state_t             state_q;
	cmd_t               cur_q;
	logic [CNTW-1:0]    issue_q;
	logic               ev_valid_s1;
	logic [IDXW-1:0]    ev_idx_s1;
	logic [ENTRIES-1:0] valid_q;
	logic               found_q;
	logic [IDXW-1:0]    match_idx_q;
	slot_t              match_slot_q;
	logic               free_found_q;
	logic [IDXW-1:0]    free_idx_q;
	logic [NW-1:0]      emit_n_q;
	notice_t            hold_q;
	logic               hold_valid_q;
	notice_t            notice_q;
	logic               notice_valid_q;

	logic               out_free;
	logic               eval_go;
	logic               step_ok;
	logic               issue_more;
	logic               eval;
	logic               is_tick;
	logic               slot_v;
	logic               tick_emit;
	logic [15:0]        new_timer;
	logic [7:0]         resp_count;
	logic               push;
	notice_t            push_data;
	slot_t              slot;
	logic [SW-1:0]      rd_data;
	logic               rd_en;
	logic               wr_en;
	logic [IDXW-1:0]    wr_addr;
	slot_t              wr_slot;

	prtt_ram #(
		.WIDTH (SW),
		.DEPTH (ENTRIES)
	) u_slots (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (SW'(wr_slot)),
		.rd_en   (rd_en),
		.rd_addr (issue_q[IDXW-1:0]),
		.rd_data (rd_data)
	);

	assign slot       = slot_t'(rd_data);
	assign out_free   = !notice_valid_q || !notice_stall;
	assign eval_go    = !hold_valid_q || out_free;
	assign step_ok    = (state_q == B_SCAN) && (!ev_valid_s1 || eval_go);
	assign issue_more = (issue_q < CNTW'(ENTRIES));
	assign rd_en      = step_ok && issue_more;
	assign eval       = (state_q == B_SCAN) && ev_valid_s1 && eval_go;
	assign is_tick    = (cur_q.op == OP_TICK);
	assign slot_v     = valid_q[ev_idx_s1];
	assign tick_emit  = eval && is_tick && slot_v && (slot.timer <= 16'd1)
		&& (emit_n_q < NW'(MAX_RESULTS));
	assign new_timer  = (slot.timer == 16'd0) ? 16'd0 : slot.timer - 16'd1;
	assign resp_count = (match_slot_q.count == 8'd0) ? 8'd0 : match_slot_q.count - 8'd1;
	assign cmd_pop    = (state_q == B_IDLE) && cmd_valid;

	always_comb begin
		wr_en         = 1'b0;
		wr_addr       = ev_idx_s1;
		wr_slot       = slot;
		wr_slot.timer = new_timer;
		if (eval && is_tick && slot_v) begin
			wr_en = 1'b1;
		end
		if (state_q == B_DONE) begin
			case (cur_q.op)
				OP_ADD: begin
					if (!found_q && free_found_q) begin
						wr_en         = 1'b1;
						wr_addr       = free_idx_q;
						wr_slot.id    = cur_q.request_id;
						wr_slot.timer = cur_q.timeout_ticks;
						wr_slot.count = cur_q.expected_responses;
					end
				end
				OP_RESPONSE: begin
					if (found_q) begin
						wr_en         = 1'b1;
						wr_addr       = match_idx_q;
						wr_slot       = match_slot_q;
						wr_slot.count = resp_count;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		push           = 1'b0;
		push_data      = hold_q;
		push_data.last = 1'b0;
		if (tick_emit && hold_valid_q) begin
			push = 1'b1;
		end
		if ((state_q == B_FLUSH) && hold_valid_q && out_free) begin
			push           = 1'b1;
			push_data.last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= B_IDLE;
			cur_q          <= '0;
			issue_q        <= '0;
			ev_valid_s1    <= 1'b0;
			ev_idx_s1      <= '0;
			valid_q        <= '0;
			found_q        <= 1'b0;
			match_idx_q    <= '0;
			match_slot_q   <= '0;
			free_found_q   <= 1'b0;
			free_idx_q     <= '0;
			emit_n_q       <= '0;
			hold_q         <= '0;
			hold_valid_q   <= 1'b0;
			notice_q       <= '0;
			notice_valid_q <= 1'b0;
		end else begin
			if (push) begin
				notice_q       <= push_data;
				notice_valid_q <= 1'b1;
			end else if (!notice_stall) begin
				notice_valid_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (cmd_valid) begin
						cur_q        <= cmd;
						issue_q      <= '0;
						ev_valid_s1  <= 1'b0;
						found_q      <= 1'b0;
						free_found_q <= 1'b0;
						emit_n_q     <= '0;
						state_q      <= B_SCAN;
					end
				end
				B_SCAN: begin
					if (step_ok) begin
						if (issue_more) begin
							ev_valid_s1 <= 1'b1;
							ev_idx_s1   <= issue_q[IDXW-1:0];
							issue_q     <= issue_q + 1'b1;
						end else begin
							ev_valid_s1 <= 1'b0;
						end
					end
					if (eval && !is_tick) begin
						if (slot_v && (slot.id == cur_q.request_id) && !found_q) begin
							found_q      <= 1'b1;
							match_idx_q  <= ev_idx_s1;
							match_slot_q <= slot;
						end
						if (!slot_v && !free_found_q) begin
							free_found_q <= 1'b1;
							free_idx_q   <= ev_idx_s1;
						end
					end
					if (tick_emit) begin
						valid_q[ev_idx_s1] <= 1'b0;
						emit_n_q           <= emit_n_q + 1'b1;
						hold_q             <= '{EV_TIMEOUT, slot.id, slot.count, 1'b0};
						hold_valid_q       <= 1'b1;
					end
					if (!issue_more && !ev_valid_s1) begin
						state_q <= B_DONE;
					end
				end
				B_DONE: begin
					case (cur_q.op)
						OP_ADD: begin
							if (found_q || !free_found_q) begin
								hold_q       <= '{EV_REJECT, cur_q.request_id, 8'd0, 1'b0};
								hold_valid_q <= 1'b1;
							end else begin
								valid_q[free_idx_q] <= 1'b1;
							end
						end
						OP_RESPONSE: begin
							if (found_q) begin
								hold_q       <= '{EV_SUCCESS, cur_q.request_id, resp_count, 1'b0};
								hold_valid_q <= 1'b1;
								if (resp_count == 8'd0) begin
									valid_q[match_idx_q] <= 1'b0;
								end
							end
						end
						OP_CANCEL: begin
							if (found_q) begin
								valid_q[match_idx_q] <= 1'b0;
								if (!cur_q.silent) begin
									hold_q       <= '{EV_TIMEOUT, cur_q.request_id,
										match_slot_q.count, 1'b0};
									hold_valid_q <= 1'b1;
								end
							end
						end
						default: begin
						end
					endcase
					state_q <= B_FLUSH;
				end
				B_FLUSH: begin
					if (!hold_valid_q) begin
						state_q <= B_IDLE;
					end else if (out_free) begin
						hold_valid_q <= 1'b0;
						state_q      <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	assign notice       = notice_q;
	assign notice_valid = notice_valid_q;

endmodule
`default_nettype wire

>>> rtl/pending_request_timeout_table_core.sv
// Top level of the pending request timeout table.
//
// Request channel: request_valid, request_stall, request. A transfer carries one
// action: add, response, cancel or timer tick. Notice channel: notice_valid,
// notice_stall, notice. Each request gives zero or more notices; the final one
// of a request has last set.
// The front end queues up to two commands, so requests are taken while the
// back end is still busy. The back end scans the table through the slot RAM
// read port, one entry per cycle unless the scan pauses, so one command
// occupies it until its scan is done and its last notice has left the hold register.
// A tick may give up to 16 notices; each one waits in a hold register and the
// scan pauses while the hold register is full and the output register is full and stalled.
// While notice_stall is high the notice holds and the scan waits once the hold
// register is full; requests are still queued until the queue is full, then
// request_stall rises. Reset empties the table (all valid bits cleared at once)
// and the queue; the first request is taken in the cycle after reset is released.
`default_nettype none
module pending_request_timeout_table_core import prtt_pkg::*; #(
	parameter int ENTRIES = ENTRIES_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     request_valid,
	output logic          request_stall,
	input  wire request_t request,
	output logic          notice_valid,
	input  wire logic     notice_stall,
	output notice_t       notice
);

	logic cmd_valid;
	logic cmd_pop;
	cmd_t cmd;

	prtt_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.request_valid (request_valid),
		.request_stall (request_stall),
		.request       (request),
		.cmd_valid     (cmd_valid),
		.cmd_pop       (cmd_pop),
		.cmd           (cmd)
	);

	prtt_back #(
		.ENTRIES (ENTRIES)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd_pop      (cmd_pop),
		.cmd          (cmd),
		.notice_valid (notice_valid),
		.notice_stall (notice_stall),
		.notice       (notice)
	);

endmodule
`default_nettype wire
